// ----- design/lprt_pkg.sv -----
// Shared types and constants for the LRU page residency tracker.
package lprt_pkg;

    localparam int PAGE_W  = 24;
    localparam int STAMP_W = 32;
    localparam int CFG_W   = 6;

    localparam logic [CFG_W-1:0] CACHE_SIZE_RST = 6'd63;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_FLUSH  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        BOP_NONE  = 2'd0,
        BOP_READ  = 2'd1,
        BOP_WRITE = 2'd2,
        BOP_FREE  = 2'd3
    } t_bop;

    typedef struct packed {
        logic               valid;
        logic [PAGE_W-1:0]  page;
        logic [STAMP_W-1:0] stamp;
    } t_slot;

    typedef struct packed {
        logic [PAGE_W-1:0]  page;
        logic [STAMP_W-1:0] stamp;
    } t_qent;

endpackage

// ----- design/lprt_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
module lprt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/lru_page_residency_tracker.sv -----
// Top level of the LRU page residency tracker: scan sequencer, access queue and slot table.
//
// Each command is taken with start while busy is low and answered by a one-cycle done strobe
// with the result; the receiver cannot stall it. All work runs through one page comparator
// that walks the slot RAM one entry per cycle. Load or write scans the slots, writes the slot
// and pushes the access; when the access queue overflows, its oldest entry is popped and
// looked up again with a second scan. Remove scans and frees a resident page's slot, and
// flush clears every slot. After reset the slot RAM is cleared with busy high; configuration
// writes are always taken, and a new cache size takes effect only while the access queue is empty.
module lru_page_residency_tracker #(
    parameter int CAPACITY = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [1:0]                  i_command,
    input  logic [lprt_pkg::PAGE_W-1:0] i_page_id,
    output logic                        o_done,
    output logic                        o_was_resident,
    output logic [1:0]                  o_backing_op,
    output logic                        o_evict_valid,
    output logic [lprt_pkg::PAGE_W-1:0] o_evict_page,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lprt_pkg::CFG_W-1:0]  i_cfg_data
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int LIM_W = (CNT_W > lprt_pkg::CFG_W) ? CNT_W : lprt_pkg::CFG_W;
    localparam int SLOT_W = $bits(lprt_pkg::t_slot);
    localparam int QENT_W = $bits(lprt_pkg::t_qent);

    typedef enum logic [9:0] {
        S_INIT     = 10'b00_0000_0001,
        S_IDLE     = 10'b00_0000_0010,
        S_FLUSH    = 10'b00_0000_0100,
        S_SCAN     = 10'b00_0000_1000,
        S_TAIL     = 10'b00_0001_0000,
        S_SLOT_WR  = 10'b00_0010_0000,
        S_PUSH     = 10'b00_0100_0000,
        S_CHECK    = 10'b00_1000_0000,
        S_POP_WAIT = 10'b01_0000_0000,
        S_DONE     = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    logic [lprt_pkg::CFG_W-1:0]   r_cache_size;
    logic [IDX_W-1:0]             r_head;
    logic [CNT_W-1:0]             r_count;
    logic [lprt_pkg::STAMP_W-1:0] r_tick;

    lprt_pkg::t_cmd               r_cmd;
    logic [lprt_pkg::PAGE_W-1:0]  r_page;
    logic [lprt_pkg::PAGE_W-1:0]  r_key;
    logic [lprt_pkg::STAMP_W-1:0] r_qstamp;
    logic                         r_evict_phase;

    logic [CNT_W-1:0]             r_addr;
    logic                         r_chk_vld;
    logic [IDX_W-1:0]             r_chk_idx;
    logic                         r_hit;
    logic [IDX_W-1:0]             r_hit_idx;
    logic [lprt_pkg::STAMP_W-1:0] r_hit_stamp;
    logic                         r_free_found;
    logic [IDX_W-1:0]             r_free_idx;

    logic                         r_resident;
    lprt_pkg::t_bop               r_bop;
    logic                         r_ev;
    logic [lprt_pkg::PAGE_W-1:0]  r_evp;

    logic              slot_wr_en;
    logic [IDX_W-1:0]  slot_wr_addr;
    lprt_pkg::t_slot   slot_wr_data;
    logic              slot_rd_en;
    logic [SLOT_W-1:0] slot_rd_raw;
    lprt_pkg::t_slot   slot_rd;

    logic              q_wr_en;
    logic [IDX_W-1:0]  q_wr_addr;
    lprt_pkg::t_qent   q_wr_data;
    logic              q_rd_en;
    logic [QENT_W-1:0] q_rd_raw;
    lprt_pkg::t_qent   q_rd;

    logic              accept;
    logic              scan_last;
    logic              slot_match;
    logic              slot_free;
    logic              evict_hit;
    logic [LIM_W-1:0]  limit;
    logic              over_limit;
    logic [CNT_W:0]    tail_sum;
    logic [CNT_W:0]    tail_wrap;
    logic [IDX_W-1:0]  head_next;

    assign accept    = (r_state == S_IDLE) && i_start;
    assign scan_last = (r_addr == CNT_W'(CAPACITY - 1));

    assign slot_rd    = lprt_pkg::t_slot'(slot_rd_raw);
    assign q_rd       = lprt_pkg::t_qent'(q_rd_raw);
    assign slot_match = r_chk_vld && slot_rd.valid && (slot_rd.page == r_key);
    assign slot_free  = r_chk_vld && !slot_rd.valid;
    assign evict_hit  = r_hit && (r_hit_stamp == r_qstamp) && !r_ev;

    // The effective queue limit saturates one below the queue depth.
    assign limit = (LIM_W'(r_cache_size) > LIM_W'(CAPACITY - 1)) ?
                   LIM_W'(CAPACITY - 1) : LIM_W'(r_cache_size);
    assign over_limit = LIM_W'(r_count) > limit;

    assign tail_sum  = (CNT_W + 1)'(r_head) + (CNT_W + 1)'(r_count);
    assign tail_wrap = (tail_sum >= (CNT_W + 1)'(CAPACITY)) ?
                       tail_sum - (CNT_W + 1)'(CAPACITY) : tail_sum;
    assign head_next = (r_head == IDX_W'(CAPACITY - 1)) ? '0 : r_head + 1'b1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (scan_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = (lprt_pkg::t_cmd'(i_command) == lprt_pkg::CMD_FLUSH) ?
                              S_FLUSH : S_SCAN;
                end
            end
            S_FLUSH: begin
                if (scan_last) n_state = S_DONE;
            end
            S_SCAN: begin
                if (scan_last) n_state = S_TAIL;
            end
            S_TAIL: n_state = S_SLOT_WR;
            S_SLOT_WR: begin
                if (r_evict_phase) begin
                    n_state = S_CHECK;
                end else if (r_cmd == lprt_pkg::CMD_REMOVE) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: n_state = S_CHECK;
            S_CHECK: n_state = over_limit ? S_POP_WAIT : S_DONE;
            S_POP_WAIT: n_state = S_SCAN;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_INIT;
        endcase
    end

    // Slot RAM port control.
    always_comb begin
        slot_wr_en   = 1'b0;
        slot_wr_addr = r_addr[IDX_W-1:0];
        slot_wr_data = '0;
        if ((r_state == S_INIT) || (r_state == S_FLUSH)) begin
            slot_wr_en = 1'b1;
        end else if (r_state == S_SLOT_WR) begin
            if (r_evict_phase) begin
                slot_wr_en   = evict_hit;
                slot_wr_addr = r_hit_idx;
                slot_wr_data = '{valid: 1'b0, page: r_key, stamp: r_hit_stamp};
            end else if (r_cmd == lprt_pkg::CMD_REMOVE) begin
                slot_wr_en   = r_hit;
                slot_wr_addr = r_hit_idx;
                slot_wr_data = '{valid: 1'b0, page: r_key, stamp: r_hit_stamp};
            end else begin
                slot_wr_en   = 1'b1;
                slot_wr_addr = r_hit ? r_hit_idx : (r_free_found ? r_free_idx : '0);
                slot_wr_data = '{valid: 1'b1, page: r_page, stamp: r_tick};
            end
        end
    end

    assign slot_rd_en = (r_state == S_SCAN);

    assign q_wr_en   = (r_state == S_PUSH) && (r_count < CNT_W'(CAPACITY));
    assign q_wr_addr = tail_wrap[IDX_W-1:0];
    assign q_wr_data = '{page: r_page, stamp: r_tick};
    assign q_rd_en   = (r_state == S_CHECK) && over_limit;

    lprt_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (slot_wr_en),
        .i_wr_addr (slot_wr_addr),
        .i_wr_data (slot_wr_data),
        .i_rd_en   (slot_rd_en),
        .i_rd_addr (r_addr[IDX_W-1:0]),
        .o_rd_data (slot_rd_raw)
    );

    lprt_ram #(
        .WIDTH (QENT_W),
        .DEPTH (CAPACITY)
    ) u_queue_ram (
        .i_clk     (i_clk),
        .i_wr_en   (q_wr_en),
        .i_wr_addr (q_wr_addr),
        .i_wr_data (q_wr_data),
        .i_rd_en   (q_rd_en),
        .i_rd_addr (r_head),
        .o_rd_data (q_rd_raw)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_INIT;
            r_cache_size  <= lprt_pkg::CACHE_SIZE_RST;
            r_head        <= '0;
            r_count       <= '0;
            r_tick        <= '0;
            r_addr        <= '0;
            r_chk_vld     <= 1'b0;
            r_hit         <= 1'b0;
            r_free_found  <= 1'b0;
            r_evict_phase <= 1'b0;
            r_ev          <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_chk_vld <= slot_rd_en;

            if (i_cfg_valid && (r_count == '0)) begin
                r_cache_size <= i_cfg_data;
            end

            if (slot_match && !r_hit) r_hit <= 1'b1;
            if (slot_free && !r_free_found) r_free_found <= 1'b1;

            unique case (r_state)
                S_INIT, S_FLUSH, S_SCAN: begin
                    r_addr <= r_addr + 1'b1;
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_addr        <= '0;
                        r_hit         <= 1'b0;
                        r_free_found  <= 1'b0;
                        r_evict_phase <= 1'b0;
                        r_ev          <= 1'b0;
                        if (lprt_pkg::t_cmd'(i_command) == lprt_pkg::CMD_FLUSH) begin
                            r_head  <= '0;
                            r_count <= '0;
                        end
                    end
                end
                S_SLOT_WR: begin
                    if (r_evict_phase && evict_hit) r_ev <= 1'b1;
                end
                S_PUSH: begin
                    if (q_wr_en) r_count <= r_count + 1'b1;
                    r_tick <= r_tick + 1'b1;
                end
                S_CHECK: begin
                    if (over_limit) begin
                        r_head  <= head_next;
                        r_count <= r_count - 1'b1;
                    end
                end
                S_POP_WAIT: begin
                    r_addr        <= '0;
                    r_hit         <= 1'b0;
                    r_free_found  <= 1'b0;
                    r_evict_phase <= 1'b1;
                end
                S_TAIL, S_DONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_chk_idx <= r_addr[IDX_W-1:0];
        if (slot_match && !r_hit) begin
            r_hit_idx   <= r_chk_idx;
            r_hit_stamp <= slot_rd.stamp;
        end
        if (slot_free && !r_free_found) begin
            r_free_idx <= r_chk_idx;
        end

        if (accept) begin
            r_cmd      <= lprt_pkg::t_cmd'(i_command);
            r_page     <= i_page_id;
            r_key      <= i_page_id;
            r_resident <= 1'b0;
            r_bop      <= lprt_pkg::BOP_NONE;
            r_evp      <= '0;
        end

        if (r_state == S_POP_WAIT) begin
            r_key    <= q_rd.page;
            r_qstamp <= q_rd.stamp;
        end

        if (r_state == S_SLOT_WR) begin
            if (r_evict_phase) begin
                if (evict_hit) r_evp <= r_key;
            end else if (r_cmd == lprt_pkg::CMD_REMOVE) begin
                r_resident <= r_hit;
                r_bop      <= lprt_pkg::BOP_FREE;
            end else begin
                r_resident <= r_hit;
                if (r_cmd == lprt_pkg::CMD_WRITE) begin
                    r_bop <= lprt_pkg::BOP_WRITE;
                end else begin
                    r_bop <= r_hit ? lprt_pkg::BOP_NONE : lprt_pkg::BOP_READ;
                end
            end
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_done         = (r_state == S_DONE);
    assign o_was_resident = r_resident;
    assign o_backing_op   = r_bop;
    assign o_evict_valid  = r_ev;
    assign o_evict_page   = r_evp;
    assign o_cfg_ready    = 1'b1;

    // Between commands the queue never holds more entries than the limit allows.
    a_count_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (LIM_W'(r_count) <= limit))
        else $error("access queue longer than the cache size while idle");

    // A result without an eviction reports page zero.
    a_evict_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_evict_valid) |-> (o_evict_page == '0))
        else $error("evict page nonzero without an eviction");

    // Remove and flush push nothing, so they never evict.
    a_no_evict_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && ((r_cmd == lprt_pkg::CMD_REMOVE) || (r_cmd == lprt_pkg::CMD_FLUSH)))
        |-> !o_evict_valid)
        else $error("eviction reported for remove or flush");

    // Each transfer yields exactly one result strobe, never two in a row.
    a_single_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // The eviction scan only runs after a pop from the queue.
    a_evict_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP_WAIT) |-> ($past(r_state) == S_CHECK))
        else $error("queue read data used without a pop");

endmodule

// ----- test/lprt_result_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard that predicts each page tracker response and compares it with the one observed.
module lprt_result_checker #(
    parameter int CAPACITY = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic [1:0]                  i_command,
    input  logic [lprt_pkg::PAGE_W-1:0] i_page_id,
    input  logic                        i_done,
    input  logic                        i_was_resident,
    input  logic [1:0]                  i_backing_op,
    input  logic                        i_evict_valid,
    input  logic [lprt_pkg::PAGE_W-1:0] i_evict_page,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [lprt_pkg::CFG_W-1:0]  i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending
);

    localparam int MAX_PRINTED = 100;
    localparam int PAGE_W      = lprt_pkg::PAGE_W;
    localparam int STAMP_W     = lprt_pkg::STAMP_W;
    localparam int CFG_W       = lprt_pkg::CFG_W;

    typedef struct packed {
        logic              was_resident;
        lprt_pkg::t_bop    backing_op;
        logic              evict_valid;
        logic [PAGE_W-1:0] evict_page;
    } t_outcome;

    // Residency is a map from page id to the stamp of its latest access.
    logic [CFG_W-1:0]   cache_size;
    logic [STAMP_W-1:0] stamp_of_page [bit [PAGE_W-1:0]];
    lprt_pkg::t_qent    access_q [$];
    logic [STAMP_W-1:0] access_tick;
    t_outcome           expected_q [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (o_fail_count < MAX_PRINTED)
            $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    task automatic predict_access(input lprt_pkg::t_cmd cmd, input logic [PAGE_W-1:0] page);
        t_outcome        outcome;
        lprt_pkg::t_qent oldest;
        int              limit;
        outcome = '0;
        case (cmd)
            lprt_pkg::CMD_FLUSH: begin
                stamp_of_page.delete();
                access_q.delete();
            end
            lprt_pkg::CMD_REMOVE: begin
                if (stamp_of_page.exists(page)) begin
                    outcome.was_resident = 1'b1;
                    stamp_of_page.delete(page);
                end
                outcome.backing_op = lprt_pkg::BOP_FREE;
            end
            default: begin
                if (stamp_of_page.exists(page)) begin
                    outcome.was_resident = 1'b1;
                    outcome.backing_op   = (cmd == lprt_pkg::CMD_WRITE) ?
                                           lprt_pkg::BOP_WRITE : lprt_pkg::BOP_NONE;
                end else begin
                    outcome.backing_op   = (cmd == lprt_pkg::CMD_WRITE) ?
                                           lprt_pkg::BOP_WRITE : lprt_pkg::BOP_READ;
                end
                stamp_of_page[page] = access_tick;
                if (access_q.size() < CAPACITY)
                    access_q.push_back('{page: page, stamp: access_tick});
                access_tick++;
                // The queue limit saturates one below the queue depth.
                limit = (int'(cache_size) > CAPACITY - 1) ? CAPACITY - 1 : int'(cache_size);
                // A popped entry evicts its page only if it is still the latest access to it.
                while (access_q.size() > limit) begin
                    oldest = access_q.pop_front();
                    if (stamp_of_page.exists(oldest.page) && !outcome.evict_valid &&
                            stamp_of_page[oldest.page] == oldest.stamp) begin
                        stamp_of_page.delete(oldest.page);
                        outcome.evict_valid = 1'b1;
                        outcome.evict_page  = oldest.page;
                    end
                end
            end
        endcase
        expected_q.push_back(outcome);
    endtask

    task automatic check_response();
        t_outcome want;
        if (expected_q.size() == 0) begin
            report_mismatch("response with no access outstanding", 32'(i_evict_page), '0);
        end else begin
            want = expected_q.pop_front();
            if (i_was_resident !== want.was_resident)
                report_mismatch("was_resident", 32'(i_was_resident), 32'(want.was_resident));
            if (i_backing_op !== want.backing_op)
                report_mismatch("backing_op", 32'(i_backing_op), 32'(want.backing_op));
            if (i_evict_valid !== want.evict_valid)
                report_mismatch("evict_valid", 32'(i_evict_valid), 32'(want.evict_valid));
            if (i_evict_page !== want.evict_page)
                report_mismatch("evict_page", 32'(i_evict_page), 32'(want.evict_page));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cache_size  = lprt_pkg::CACHE_SIZE_RST;
            access_tick = '0;
            stamp_of_page.delete();
            access_q.delete();
        end else begin
            if (i_done)
                check_response();
            if (i_start && !i_busy)
                predict_access(lprt_pkg::t_cmd'(i_command), i_page_id);
            // A new cache size only lands while the access queue is empty.
            if (i_cfg_valid && i_cfg_ready && access_q.size() == 0)
                cache_size = i_cfg_data;
        end
        o_pending = expected_q.size();
    end

endmodule

// ----- test/lru_page_residency_tracker_tb.sv -----
`timescale 1ns / 100ps
// Top of the page tracker testbench: clock, reset, access and cache size stimulus, verdict.
module lru_page_residency_tracker_tb;

    localparam int CAPACITY     = 64;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 40;
    localparam int POOL_DEPTH   = 96;
    localparam int PAGE_W       = lprt_pkg::PAGE_W;
    localparam int CFG_W        = lprt_pkg::CFG_W;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_start;
    logic              o_busy;
    logic [1:0]        i_command;
    logic [PAGE_W-1:0] i_page_id;
    logic              o_done;
    logic              o_was_resident;
    logic [1:0]        o_backing_op;
    logic              o_evict_valid;
    logic [PAGE_W-1:0] o_evict_page;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CFG_W-1:0]  i_cfg_data;

    int fail_count;
    int pending;
    int cycle_count = 0;
    bit quiet_stretch;
    bit deep_phase;
    int pool_n;

    logic [PAGE_W-1:0] page_pool [0:POOL_DEPTH-1];

    lru_page_residency_tracker #(
        .CAPACITY(CAPACITY)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_command      (i_command),
        .i_page_id      (i_page_id),
        .o_done         (o_done),
        .o_was_resident (o_was_resident),
        .o_backing_op   (o_backing_op),
        .o_evict_valid  (o_evict_valid),
        .o_evict_page   (o_evict_page),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    lprt_result_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_busy         (o_busy),
        .i_command      (i_command),
        .i_page_id      (i_page_id),
        .i_done         (o_done),
        .i_was_resident (o_was_resident),
        .i_backing_op   (o_backing_op),
        .i_evict_valid  (o_evict_valid),
        .i_evict_page   (o_evict_page),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // One access transfer; start is dropped right after it so busy always sees it low again.
    task automatic issue_access(input lprt_pkg::t_cmd cmd, input logic [PAGE_W-1:0] page);
        int gap;
        gap = 0;
        if (!quiet_stretch && $urandom_range(0, 99) < 16)
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 100) : $urandom_range(1, 4);
        repeat (gap) @(negedge i_clk);
        @(negedge i_clk);
        i_start   = 1'b1;
        i_command = cmd;
        i_page_id = page;
        do @(posedge i_clk); while (o_busy);
        @(negedge i_clk);
        i_start = 1'b0;
    endtask

    task automatic write_cache_size(input logic [CFG_W-1:0] size);
        @(negedge i_clk);
        while (pending != 0 || o_busy) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = size;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic lprt_pkg::t_cmd pick_command();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return lprt_pkg::CMD_LOAD;
        if (roll < 77)
            return lprt_pkg::CMD_WRITE;
        if (roll < 96 || deep_phase)
            return lprt_pkg::CMD_REMOVE;
        return lprt_pkg::CMD_FLUSH;
    endfunction

    function automatic logic [PAGE_W-1:0] pick_page();
        if ($urandom_range(0, 99) < 85)
            return page_pool[$urandom_range(0, pool_n - 1)];
        return PAGE_W'($urandom);
    endfunction

    initial begin
        int phase;
        int n;
        int item_total;
        logic [CFG_W-1:0] size;

        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_command     = lprt_pkg::CMD_LOAD;
        i_page_id     = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        quiet_stretch = 1'b0;
        deep_phase    = 1'b0;
        pool_n        = 1;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // With a cache size of zero every access evicts the page it just touched.
        write_cache_size(6'd0);
        issue_access(lprt_pkg::CMD_LOAD, 24'h000000);
        issue_access(lprt_pkg::CMD_WRITE, 24'hFFFFFF);
        issue_access(lprt_pkg::CMD_REMOVE, 24'h000000);
        issue_access(lprt_pkg::CMD_FLUSH, 24'hFFFFFF);

        // Two entries: hits, misses, stale entries left by a re-access and by remove.
        write_cache_size(6'd2);
        issue_access(lprt_pkg::CMD_LOAD, 24'h000001);
        issue_access(lprt_pkg::CMD_LOAD, 24'hFFFFFF);
        issue_access(lprt_pkg::CMD_LOAD, 24'h000001);
        issue_access(lprt_pkg::CMD_LOAD, 24'h000000);
        issue_access(lprt_pkg::CMD_WRITE, 24'h000001);
        issue_access(lprt_pkg::CMD_REMOVE, 24'h000000);
        issue_access(lprt_pkg::CMD_LOAD, 24'hAAAAAA);
        issue_access(lprt_pkg::CMD_LOAD, 24'h555555);

        // The queue is not empty, so this size is dropped and two entries remain the limit.
        write_cache_size(6'd63);
        issue_access(lprt_pkg::CMD_LOAD, 24'h123456);
        issue_access(lprt_pkg::CMD_WRITE, 24'h654321);
        issue_access(lprt_pkg::CMD_REMOVE, 24'h999999);
        issue_access(lprt_pkg::CMD_FLUSH, 24'h000000);

        write_cache_size(6'd63);
        issue_access(lprt_pkg::CMD_LOAD, 24'h800000);
        issue_access(lprt_pkg::CMD_WRITE, 24'h800000);
        issue_access(lprt_pkg::CMD_REMOVE, 24'h800000);
        issue_access(lprt_pkg::CMD_WRITE, 24'h000000);
        issue_access(lprt_pkg::CMD_LOAD, 24'hFFFFFF);

        for (phase = 0; phase < 10; phase++) begin
            deep_phase    = (phase == 1 || phase == 6);
            quiet_stretch = (phase == 4);
            pool_n        = deep_phase ? 80 : $urandom_range(2, 24);
            for (n = 0; n < POOL_DEPTH; n++)
                page_pool[n] = (n % 8 == 7) ? PAGE_W'($urandom_range(0, 15)) : PAGE_W'($urandom);
            if (phase % 2 == 0) begin
                page_pool[0] = '0;
                page_pool[1] = '1;
            end
            case (phase)
                0:       size = 6'd1;
                1:       size = 6'd63;
                2:       size = 6'd0;
                3:       size = 6'd0;
                4:       size = CFG_W'($urandom_range(2, 8));
                6:       size = 6'd63;
                8:       size = 6'd5;
                default: size = CFG_W'($urandom_range(0, 63));
            endcase
            // Phases that skip the flush usually see their size write ignored.
            if (phase % 3 != 2)
                issue_access(lprt_pkg::CMD_FLUSH, PAGE_W'($urandom));
            write_cache_size(size);
            item_total = deep_phase ? 100 : 45;
            for (n = 0; n < item_total; n++)
                issue_access(pick_command(), pick_page());
        end
        quiet_stretch = 1'b0;

        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
